// File: rtl/sbda_pkg.sv
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared types and constants for the signed binary to decimal ASCII unit.
// ----------------------------------------------------------------------------
package sbda_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned CharW     = 8;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = NumDigits * DigitW;
  localparam int unsigned BitCntW   = $clog2(ValueW);
  localparam int unsigned DigCntW   = $clog2(NumDigits + 1);

  localparam logic [CharW-1:0]  CharMinus = 8'd45;
  localparam logic [CharW-1:0]  CharZero  = 8'd48;
  localparam logic [DigitW-1:0] DabbleMin = 4'd5;
  localparam logic [DigitW-1:0] DabbleAdd = 4'd3;

  typedef enum logic [1:0] {
    DbIdle,
    DbRun,
    DbHold
  } sbda_dab_state_e;

  typedef enum logic [1:0] {
    EmIdle,
    EmSkip,
    EmSign,
    EmDigit
  } sbda_emit_state_e;

  // finished conversion handed from the converter to the emitter
  typedef struct packed {
    logic            valid;
    logic            neg;
    logic [BcdW-1:0] bcd;
  } sbda_conv_t;

  // add three to every bcd digit that is five or more
  function automatic logic [BcdW-1:0] dabble_adjust(input logic [BcdW-1:0] bcd);
    logic [BcdW-1:0]   res;
    logic [DigitW-1:0] dig;
    res = bcd;
    for (int i = 0; i < NumDigits; i++) begin
      dig = bcd[i*DigitW +: DigitW];
      if (dig >= DabbleMin) begin
        res[i*DigitW +: DigitW] = dig + DabbleAdd;
      end
    end
    return res;
  endfunction

endpackage

// File: rtl/sbda_if.sv
// ----------------------------------------------------------------------------
// sbda_in_if / sbda_out_if
// Valid/ready channels for input values and output characters.
// ----------------------------------------------------------------------------
interface sbda_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sbda_pkg::ValueW-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sbda_out_if;
  logic                        valid;
  logic                        ready;
  logic [sbda_pkg::CharW-1:0]  character;
  logic                        last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// File: rtl/sbda_dabble.sv
// ----------------------------------------------------------------------------
// sbda_dabble
// Bit-serial shift-and-add-3 conversion of the magnitude to ten bcd digits.
// ----------------------------------------------------------------------------
module sbda_dabble (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sbda_in_if.sink              in_i,
  output sbda_pkg::sbda_conv_t conv_o,
  input  logic                 take_i
);

  sbda_pkg::sbda_dab_state_e         state_q, state_d;
  logic [sbda_pkg::ValueW-1:0]       mag_q, mag_d;
  logic [sbda_pkg::BcdW-1:0]         bcd_q, bcd_d;
  logic [sbda_pkg::BitCntW-1:0]      cnt_q, cnt_d;
  logic                              neg_q, neg_d;
  logic [sbda_pkg::BcdW-1:0]         bcd_adj;
  logic                              accept;
  logic                              last_bit;

  assign bcd_adj  = sbda_pkg::dabble_adjust(bcd_q);
  assign last_bit = (cnt_q == sbda_pkg::BitCntW'(sbda_pkg::ValueW - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sbda_pkg::DbIdle: begin
        if (in_i.valid) state_d = sbda_pkg::DbRun;
      end
      sbda_pkg::DbRun: begin
        if (last_bit) state_d = sbda_pkg::DbHold;
      end
      sbda_pkg::DbHold: begin
        if (take_i) state_d = sbda_pkg::DbIdle;
      end
      default: state_d = sbda_pkg::DbIdle;
    endcase
  end

  // outputs
  always_comb begin
    in_i.ready   = 1'b0;
    conv_o.valid = 1'b0;
    case (state_q)
      sbda_pkg::DbIdle: in_i.ready   = 1'b1;
      sbda_pkg::DbHold: conv_o.valid = 1'b1;
      default: ;
    endcase
  end

  assign conv_o.neg = neg_q;
  assign conv_o.bcd = bcd_q;
  assign accept     = in_i.valid && in_i.ready;

  // datapath
  always_comb begin
    mag_d = mag_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    if (accept) begin
      neg_d = in_i.value[sbda_pkg::ValueW-1];
      mag_d = neg_d ? (~in_i.value + 1'b1) : in_i.value;
      bcd_d = '0;
      cnt_d = '0;
    end else if (state_q == sbda_pkg::DbRun) begin
      bcd_d = {bcd_adj[sbda_pkg::BcdW-2:0], mag_q[sbda_pkg::ValueW-1]};
      mag_d = {mag_q[sbda_pkg::ValueW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbda_pkg::DbIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
  end

endmodule

// File: rtl/sbda_emit.sv
// ----------------------------------------------------------------------------
// sbda_emit
// Skips leading zero digits, then sends sign and digits one per beat.
// ----------------------------------------------------------------------------
module sbda_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sbda_pkg::sbda_conv_t conv_i,
  output logic                 take_o,
  sbda_out_if.source           out_o
);

  sbda_pkg::sbda_emit_state_e     state_q, state_d;
  logic [sbda_pkg::BcdW-1:0]      dig_q, dig_d;
  logic [sbda_pkg::DigCntW-1:0]   cnt_q, cnt_d;
  logic                           neg_q, neg_d;
  logic                           ovalid_q, ovalid_d;
  logic [sbda_pkg::CharW-1:0]     ochar_q, ochar_d;
  logic                           olast_q, olast_d;
  logic [sbda_pkg::DigitW-1:0]    top_dig;
  logic                           slot_free;
  logic                           one_left;
  logic                           skip_more;

  assign top_dig   = dig_q[sbda_pkg::BcdW-1 -: sbda_pkg::DigitW];
  assign slot_free = !ovalid_q || out_o.ready;
  assign one_left  = (cnt_q == sbda_pkg::DigCntW'(1));
  assign skip_more = (top_dig == '0) && !one_left;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sbda_pkg::EmIdle: begin
        if (conv_i.valid) state_d = sbda_pkg::EmSkip;
      end
      sbda_pkg::EmSkip: begin
        if (!skip_more) state_d = neg_q ? sbda_pkg::EmSign : sbda_pkg::EmDigit;
      end
      sbda_pkg::EmSign: begin
        if (slot_free) state_d = sbda_pkg::EmDigit;
      end
      sbda_pkg::EmDigit: begin
        if (slot_free && one_left) state_d = sbda_pkg::EmIdle;
      end
      default: state_d = sbda_pkg::EmIdle;
    endcase
  end

  // outputs and datapath
  always_comb begin
    take_o   = 1'b0;
    dig_d    = dig_q;
    cnt_d    = cnt_q;
    neg_d    = neg_q;
    ovalid_d = ovalid_q && !out_o.ready;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    case (state_q)
      sbda_pkg::EmIdle: begin
        take_o = conv_i.valid;
        if (conv_i.valid) begin
          dig_d = conv_i.bcd;
          neg_d = conv_i.neg;
          cnt_d = sbda_pkg::DigCntW'(sbda_pkg::NumDigits);
        end
      end
      sbda_pkg::EmSkip: begin
        if (skip_more) begin
          dig_d = {dig_q[sbda_pkg::BcdW-sbda_pkg::DigitW-1:0], {sbda_pkg::DigitW{1'b0}}};
          cnt_d = cnt_q - 1'b1;
        end
      end
      sbda_pkg::EmSign: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          ochar_d  = sbda_pkg::CharMinus;
          olast_d  = 1'b0;
        end
      end
      sbda_pkg::EmDigit: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          ochar_d  = sbda_pkg::CharZero + {{(sbda_pkg::CharW-sbda_pkg::DigitW){1'b0}}, top_dig};
          olast_d  = one_left;
          dig_d    = {dig_q[sbda_pkg::BcdW-sbda_pkg::DigitW-1:0], {sbda_pkg::DigitW{1'b0}}};
          cnt_d    = cnt_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.character = ochar_q;
  assign out_o.last      = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sbda_pkg::EmIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q   <= dig_d;
    cnt_q   <= cnt_d;
    neg_q   <= neg_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

endmodule

// File: rtl/signed_binary_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_unit
// Formats a signed 32-bit value as decimal ascii text, one character a beat.
// ----------------------------------------------------------------------------
//  channel  dir  payload                  notes
//  in_i     in   value (32b signed)       one beat per number
//  out_o    out  character (8b), last     1 to 11 beats per number, last on final
//
//  conversion moves one magnitude bit per cycle through the bcd shift register;
//  a new value is taken only once the previous bcd result has moved to the
//  emitter, so the converter takes no new number while one is still in flight
//  emitter drops leading zeros one digit at a time, then sends each character as out_o takes it
//  output is registered; a stall on out_o holds the emitter and then the converter
//  reset clears the control state only
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbda_in_if.sink     in_i,
  sbda_out_if.source  out_o
);

  sbda_pkg::sbda_conv_t conv;
  logic                 take;

  sbda_dabble u_dabble (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .conv_o (conv),
    .take_i (take)
  );

  sbda_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .conv_i (conv),
    .take_o (take),
    .out_o  (out_o)
  );

endmodule
